// ===== sv/rvm_pkg.sv =====
package rvm_pkg;

  localparam int DATA_W        = 32;
  localparam int CNT_W         = $clog2(DATA_W);
  localparam int NUM_REGS_DEF  = 5;
  localparam int MEM_WORDS_DEF = 256;

  typedef enum logic [3:0] {
    OP_LD   = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_ST   = 4'd5,
    OP_FJ   = 4'd6,
    OP_TJ   = 4'd7,
    OP_JMP  = 4'd8,
    OP_LT   = 4'd9,
    OP_GT   = 4'd10,
    OP_EQ   = 4'd11,
    OP_LE   = 4'd12,
    OP_GE   = 4'd13,
    OP_NE   = 4'd14,
    OP_NONE = 4'd15
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_DIV_NA,
    ST_DIV_NB,
    ST_DIV_STEP,
    ST_DIV_FIX,
    ST_MUL_STEP,
    ST_WB
  } state_t;

endpackage

// ===== sv/register_vm_instruction_step.sv =====
// channel   handshake              payload
// cmd       cmd_valid / cmd_stall  func, reg_index, operand_from_memory, imm_value, mem_addr
// res       res_valid / res_stall  reg_value, jump_taken, jump_target, status
//
// ld, add, sub, st, jumps and compares go through fetch, execute and writeback from transfer to result
// mul makes 32 shift-add passes through the shared 33-bit adder
// div makes two negations, 32 restoring steps and a sign fix on that adder
// after reset a clearing pass writes zero to every word of the data memory
// a waiting result holds at res while the next command is taken; writeback waits on it
module register_vm_instruction_step #(
  parameter int NUM_REGS  = rvm_pkg::NUM_REGS_DEF,
  parameter int MEM_WORDS = rvm_pkg::MEM_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  rvm_pkg::func_t      func,
  input  logic [2:0]          reg_index,
  input  logic                operand_from_memory,
  input  logic signed [31:0]  imm_value,
  input  logic [7:0]          mem_addr,
  output logic                res_valid,
  input  logic                res_stall,
  output logic signed [31:0]  reg_value,
  output logic                jump_taken,
  output logic signed [31:0]  jump_target,
  output logic                status
);
  import rvm_pkg::*;

  localparam int MAW = $clog2(MEM_WORDS);
  localparam int AW  = (MAW > 8) ? MAW : 8;
  localparam int RAW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int RIW = (RAW > 3) ? RAW : 3;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  state_t state, state_next;

  logic [DATA_W-1:0] regs [NUM_REGS];
  logic [DATA_W-1:0] mem [MEM_WORDS];
  logic [DATA_W-1:0] mem_q;
  logic [MAW-1:0]    clr;

  func_t             func_q;
  logic [2:0]        ridx;
  logic              from_mem;
  logic [DATA_W-1:0] imm;
  logic [7:0]        addr;
  logic              addr_ok;
  logic [DATA_W-1:0] rv;
  logic [DATA_W-1:0] opnd;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] res;
  logic [CNT_W-1:0]  cnt;
  logic              neg_q;
  logic              wr_en;
  logic              taken;
  logic [DATA_W-1:0] target;
  logic              stat;

  logic [AW-1:0]     addr_w;
  logic [MAW-1:0]    addr_idx;
  logic              addr_ok_c;
  logic [RIW-1:0]    ridx_w;
  logic [RAW-1:0]    ridx_idx;
  logic              ridx_ok;
  logic [DATA_W-1:0] opnd_sel;
  logic [DATA_W-1:0] div_shift;
  logic [DATA_W:0]   alu_a, alu_b, alu_sum;
  logic              alu_sub;
  logic              cmp_lt, cmp_eq;
  logic              mem_we;
  logic [MAW-1:0]    mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic              cmd_xfer;
  logic              res_load;

  assign addr_w    = AW'(addr);
  assign addr_idx  = addr_w[MAW-1:0];
  assign addr_ok_c = {24'b0, addr} < 32'(MEM_WORDS);
  assign ridx_w    = RIW'(ridx);
  assign ridx_idx  = ridx_w[RAW-1:0];
  assign ridx_ok   = {29'b0, ridx} < 32'(NUM_REGS);
  assign opnd_sel  = from_mem ? (addr_ok ? mem_q : '0) : imm;
  assign div_shift = {rem[DATA_W-2:0], acc[DATA_W-1]};

  assign cmd_stall = (state != ST_IDLE);
  assign cmd_xfer  = cmd_valid && !cmd_stall;
  assign res_load  = (state == ST_WB) && (!res_valid || !res_stall);

  // shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_EXEC: begin
        if (func_q == OP_JMP) begin
          alu_a   = {opnd_sel[DATA_W-1], opnd_sel};
          alu_b   = (DATA_W + 1)'(1);
          alu_sub = 1'b1;
        end else begin
          alu_a   = {rv[DATA_W-1], rv};
          alu_b   = {opnd_sel[DATA_W-1], opnd_sel};
          alu_sub = (func_q != OP_ADD);
        end
      end
      ST_DIV_NA: begin
        alu_b   = {1'b0, rv};
        alu_sub = 1'b1;
      end
      ST_DIV_NB: begin
        alu_b   = {1'b0, opnd};
        alu_sub = 1'b1;
      end
      ST_DIV_STEP: begin
        alu_a   = {1'b0, div_shift};
        alu_b   = {1'b0, opnd};
        alu_sub = 1'b1;
      end
      ST_DIV_FIX: begin
        alu_b   = {1'b0, acc};
        alu_sub = 1'b1;
      end
      ST_MUL_STEP: begin
        alu_a = {1'b0, acc};
        alu_b = {1'b0, opnd};
      end
      default: begin
      end
    endcase
    alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{DATA_W{1'b0}}, alu_sub};
  end

  assign cmp_lt = alu_sum[DATA_W];
  assign cmp_eq = (rv == opnd_sel);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_idx;
    mem_wd = rv;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr;
      mem_wd = '0;
    end else if (state == ST_EXEC && func_q == OP_ST && addr_ok) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[addr_idx];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr == MAW'(MEM_WORDS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_xfer) state_next = ST_FETCH;
      end
      ST_FETCH: state_next = ST_EXEC;
      ST_EXEC: begin
        if (func_q == OP_MUL) begin
          state_next = ST_MUL_STEP;
        end else if (func_q == OP_DIV && opnd_sel != '0) begin
          state_next = ST_DIV_NA;
        end else begin
          state_next = ST_WB;
        end
      end
      ST_DIV_NA: state_next = ST_DIV_NB;
      ST_DIV_NB: state_next = ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (cnt == CNT_LAST) state_next = ST_DIV_FIX;
      end
      ST_DIV_FIX: state_next = ST_WB;
      ST_MUL_STEP: begin
        if (cnt == CNT_LAST) state_next = ST_WB;
      end
      ST_WB: begin
        if (res_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else begin
      if (state == ST_CLEAR) clr <= clr + MAW'(1);
      if (res_load) begin
        res_valid <= 1'b1;
        if (wr_en && ridx_ok) regs[ridx_idx] <= res;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      func_q   <= func;
      ridx     <= reg_index;
      from_mem <= operand_from_memory;
      imm      <= imm_value;
      addr     <= mem_addr;
    end
    if (res_load) begin
      reg_value   <= ridx_ok ? (wr_en ? res : rv) : '0;
      jump_taken  <= taken;
      jump_target <= target;
      status      <= stat;
    end
    case (state)
      ST_FETCH: begin
        rv      <= ridx_ok ? regs[ridx_idx] : '0;
        addr_ok <= addr_ok_c;
      end
      ST_EXEC: begin
        opnd   <= opnd_sel;
        wr_en  <= 1'b1;
        taken  <= 1'b0;
        target <= '0;
        stat   <= 1'b0;
        res    <= opnd_sel;
        cnt    <= '0;
        acc    <= '0;
        rem    <= opnd_sel;
        neg_q  <= rv[DATA_W-1] ^ opnd_sel[DATA_W-1];
        case (func_q)
          OP_LD:  res <= opnd_sel;
          OP_ADD: res <= alu_sum[DATA_W-1:0];
          OP_SUB: res <= alu_sum[DATA_W-1:0];
          OP_MUL: begin
            // multiplicand in opnd, multiplier in rem
            opnd <= rv;
            rem  <= opnd_sel;
          end
          OP_DIV: begin
            if (opnd_sel == '0) begin
              wr_en <= 1'b0;
              stat  <= 1'b1;
            end
          end
          OP_ST:  wr_en <= 1'b0;
          OP_FJ: begin
            wr_en <= 1'b0;
            if (rv == '0) begin
              taken  <= 1'b1;
              target <= opnd_sel;
            end
          end
          OP_TJ: begin
            wr_en <= 1'b0;
            if (rv != '0) begin
              taken  <= 1'b1;
              target <= opnd_sel;
            end
          end
          OP_JMP: begin
            wr_en  <= 1'b0;
            taken  <= 1'b1;
            target <= alu_sum[DATA_W-1:0];
          end
          OP_LT:  res <= DATA_W'(cmp_lt);
          OP_GT:  res <= DATA_W'(!cmp_lt && !cmp_eq);
          OP_EQ:  res <= DATA_W'(cmp_eq);
          OP_LE:  res <= DATA_W'(cmp_lt || cmp_eq);
          OP_GE:  res <= DATA_W'(!cmp_lt);
          OP_NE:  res <= DATA_W'(!cmp_eq);
          default: wr_en <= 1'b0;
        endcase
      end
      ST_DIV_NA: begin
        acc <= rv[DATA_W-1] ? alu_sum[DATA_W-1:0] : rv;
      end
      ST_DIV_NB: begin
        opnd <= opnd[DATA_W-1] ? alu_sum[DATA_W-1:0] : opnd;
        rem  <= '0;
        cnt  <= '0;
      end
      ST_DIV_STEP: begin
        // restoring step, quotient bits shift into acc
        if (!alu_sum[DATA_W]) begin
          rem <= alu_sum[DATA_W-1:0];
          acc <= {acc[DATA_W-2:0], 1'b1};
        end else begin
          rem <= div_shift;
          acc <= {acc[DATA_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
      end
      ST_DIV_FIX: begin
        res <= neg_q ? alu_sum[DATA_W-1:0] : acc;
      end
      ST_MUL_STEP: begin
        if (rem[0]) acc <= alu_sum[DATA_W-1:0];
        if (cnt == CNT_LAST) res <= rem[0] ? alu_sum[DATA_W-1:0] : acc;
        opnd <= {opnd[DATA_W-2:0], 1'b0};
        rem  <= {1'b0, rem[DATA_W-1:1]};
        cnt  <= cnt + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  a_xfer_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer |=> state == ST_FETCH)
    else $error("command transfer did not start a fetch");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_STEP && cnt == CNT_LAST) |=> state == ST_DIV_FIX)
    else $error("divide did not finish after the last step");

  a_no_target: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !jump_taken) |-> jump_target == '0)
    else $error("jump target set without a taken jump");

  a_status_nojump: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status) |-> !jump_taken)
    else $error("divide by zero flagged together with a jump");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import rvm_pkg::*;

  typedef struct packed {
    logic [31:0] reg_value;
    logic        jump_taken;
    logic [31:0] jump_target;
    logic        status;
  } vm_result_t;

  class step_checker;
    logic [31:0] regs [NUM_REGS_DEF];
    logic [31:0] data_mem [MEM_WORDS_DEF];
    vm_result_t  due [$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (data_mem[i]) data_mem[i] = '0;
      errors = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function logic [31:0] reg_rd(logic [2:0] ri);
      return (ri < NUM_REGS_DEF) ? regs[ri] : '0;
    endfunction

    function void reg_wr(logic [2:0] ri, logic [31:0] v);
      if (ri < NUM_REGS_DEF) regs[ri] = v;
    endfunction

    // executes one instruction on the shadow state and queues its outcome
    function void note_cmd(func_t op, logic [2:0] ri, logic from_mem, logic [31:0] imm,
                           logic [7:0] addr);
      logic [31:0] opnd;
      logic [31:0] r;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      vm_result_t  res;
      opnd = from_mem ? ((addr < MEM_WORDS_DEF) ? data_mem[addr] : '0) : imm;
      r    = reg_rd(ri);
      res  = '0;
      case (op)
        OP_LD:  reg_wr(ri, opnd);
        OP_ADD: reg_wr(ri, r + opnd);
        OP_SUB: reg_wr(ri, r - opnd);
        OP_MUL: reg_wr(ri, r * opnd);
        OP_DIV: begin
          if (opnd == '0) begin
            res.status = 1'b1;
          end else begin
            // magnitudes, then sign; most negative over minus one wraps
            ma = r[31] ? -r : r;
            mb = opnd[31] ? -opnd : opnd;
            q  = ma / mb;
            reg_wr(ri, (r[31] ^ opnd[31]) ? -q : q);
          end
        end
        OP_ST: begin
          if (addr < MEM_WORDS_DEF) data_mem[addr] = r;
        end
        OP_FJ: begin
          if (r == '0) begin
            res.jump_taken  = 1'b1;
            res.jump_target = opnd;
          end
        end
        OP_TJ: begin
          if (r != '0) begin
            res.jump_taken  = 1'b1;
            res.jump_target = opnd;
          end
        end
        OP_JMP: begin
          res.jump_taken  = 1'b1;
          res.jump_target = opnd - 32'd1;
        end
        OP_LT: reg_wr(ri, {31'b0, $signed(r) <  $signed(opnd)});
        OP_GT: reg_wr(ri, {31'b0, $signed(r) >  $signed(opnd)});
        OP_EQ: reg_wr(ri, {31'b0, $signed(r) == $signed(opnd)});
        OP_LE: reg_wr(ri, {31'b0, $signed(r) <= $signed(opnd)});
        OP_GE: reg_wr(ri, {31'b0, $signed(r) >= $signed(opnd)});
        OP_NE: reg_wr(ri, {31'b0, $signed(r) != $signed(opnd)});
        default: ;
      endcase
      res.reg_value = reg_rd(ri);
      due.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(vm_result_t got);
      vm_result_t exp;
      if (due.size() == 0) begin
        report($sformatf("result with nothing outstanding, reg_value %h", got.reg_value));
        return;
      end
      exp = due.pop_front();
      if (got.reg_value !== exp.reg_value)
        report($sformatf("reg_value %h, want %h", got.reg_value, exp.reg_value));
      if (got.jump_taken !== exp.jump_taken)
        report($sformatf("jump_taken %b, want %b", got.jump_taken, exp.jump_taken));
      if (got.jump_target !== exp.jump_target)
        report($sformatf("jump_target %h, want %h", got.jump_target, exp.jump_target));
      if (got.status !== exp.status)
        report($sformatf("status %b, want %b", got.status, exp.status));
    endtask
  endclass

  localparam int IDLE_LIMIT = 4000;

  logic               clk;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  func_t              func;
  logic [2:0]         reg_index;
  logic               operand_from_memory;
  logic signed [31:0] imm_value;
  logic [7:0]         mem_addr;
  logic               res_valid;
  logic               res_stall;
  logic signed [31:0] reg_value;
  logic               jump_taken;
  logic signed [31:0] jump_target;
  logic               status;

  step_checker sb = new();
  bit          tx_burst;
  bit          rx_burst;
  int          hold_len;
  int          idle_cycles = 0;

  register_vm_instruction_step uut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall)
        sb.note_cmd(func, reg_index, operand_from_memory, imm_value, mem_addr);
      if (res_valid && !res_stall)
        sb.check_result('{reg_value, jump_taken, jump_target, status});
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random stall before each transfer, or a long hold when asked
  initial begin
    int n;
    res_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_len > 0) n = hold_len;
      else n = rx_burst ? 0 : $urandom_range(0, 18);
      hold_len = 0;
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (res_valid !== 1'b1) @(posedge clk);
    end
  end

  task automatic send_cmd(func_t op, logic [2:0] ri, logic from_mem, logic [31:0] imm,
                          logic [7:0] addr);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid           <= 1'b1;
    func                <= op;
    reg_index           <= ri;
    operand_from_memory <= from_mem;
    imm_value           <= imm;
    mem_addr            <= addr;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 6))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      4: return $urandom_range(0, 16) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    func_t      op;
    logic [2:0] ri;
    logic [7:0] addr;
    case ($urandom_range(0, 9))
      0, 1: op = OP_LD;
      2: op = OP_ST;
      default: op = func_t'($urandom_range(0, 15));
    endcase
    ri = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    // small address pool so stores are read back often
    addr = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    send_cmd(op, ri, 1'($urandom_range(0, 1)), rand_word(), addr);
  endtask

  initial begin
    cmd_valid           <= 1'b0;
    func                <= OP_NONE;
    reg_index           <= '0;
    operand_from_memory <= 1'b0;
    imm_value           <= '0;
    mem_addr            <= '0;
    tx_burst    = 1'b0;
    rx_burst    = 1'b0;
    hold_len    = 0;
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_cmd(OP_LD,   3'd0, 1'b0, 32'h7fff_ffff, 8'd0);
    send_cmd(OP_ADD,  3'd0, 1'b0, 32'd1,         8'd0);
    send_cmd(OP_ST,   3'd0, 1'b0, 32'd0,         8'd255);
    send_cmd(OP_LD,   3'd1, 1'b1, 32'd0,         8'd255);
    send_cmd(OP_DIV,  3'd1, 1'b0, 32'hffff_ffff, 8'd0);
    send_cmd(OP_DIV,  3'd1, 1'b0, 32'd0,         8'd0);
    send_cmd(OP_LD,   3'd2, 1'b0, -32'sd7,       8'd0);
    send_cmd(OP_DIV,  3'd2, 1'b0, 32'd2,         8'd0);
    send_cmd(OP_MUL,  3'd2, 1'b0, 32'h8000_0001, 8'd0);
    send_cmd(OP_SUB,  3'd3, 1'b0, 32'd1,         8'd0);
    send_cmd(OP_MUL,  3'd1, 1'b0, 32'hffff_ffff, 8'd0);
    send_cmd(OP_FJ,   3'd4, 1'b0, 32'd77,        8'd0);
    send_cmd(OP_TJ,   3'd4, 1'b0, 32'd78,        8'd0);
    send_cmd(OP_TJ,   3'd0, 1'b1, 32'd0,         8'd255);
    send_cmd(OP_FJ,   3'd0, 1'b0, 32'd79,        8'd0);
    send_cmd(OP_JMP,  3'd3, 1'b0, 32'h8000_0000, 8'd0);
    send_cmd(OP_LT,   3'd2, 1'b0, 32'd5,         8'd0);
    send_cmd(OP_GT,   3'd3, 1'b0, 32'h8000_0000, 8'd0);
    send_cmd(OP_EQ,   3'd0, 1'b1, 32'd0,         8'd255);
    send_cmd(OP_LE,   3'd4, 1'b0, 32'd0,         8'd0);
    send_cmd(OP_GE,   3'd1, 1'b0, 32'h7fff_ffff, 8'd0);
    send_cmd(OP_NE,   3'd4, 1'b1, 32'd0,         8'd200);
    send_cmd(OP_LD,   3'd7, 1'b0, 32'd99,        8'd0);
    send_cmd(OP_ST,   3'd6, 1'b0, 32'd0,         8'd255);
    send_cmd(OP_NONE, 3'd2, 1'b0, 32'd0,         8'd0);
    drain();

    for (int phase = 0; phase < 16; phase++) begin
      tx_burst = (phase % 4 == 1);
      rx_burst = (phase % 4 == 1) || (phase == 6);
      // hold the result side off while commands keep coming
      if (phase == 3) begin
        hold_len = 400;
        tx_burst = 1'b1;
      end
      for (int k = 0; k < 100; k++) send_random();
      if (phase % 2 == 0) drain();
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
